### hdl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ufq_pkg.sv
// Package with sizes, codes and shared types of the unique FIFO queue.
`default_nettype none

package ufq_pkg;

    localparam int DEPTH        = 16;
    localparam int ELEMENT_BITS = 16;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the stream beats.
    localparam int MODE_W       = 2;
    localparam int ELEM_FIELD_W = 16;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;

    localparam int S_TDATA_W = ELEM_FIELD_W;
    localparam int S_TUSER_W = MODE_W;
    localparam int FILL_LSB  = ELEM_FIELD_W;
    localparam int M_TDATA_W = ((ELEM_FIELD_W + FILL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = M_TDATA_W - ELEM_FIELD_W - FILL_W;
    localparam int M_TUSER_W = STATUS_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic [ELEMENT_BITS-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic [ELEM_FIELD_W-1:0] out_element;
        status_t                 status;
        logic                    present;
        logic [FILL_W-1:0]       fill_count;
    } result_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
        logic [IDX_W-1:0] nxt;
        if (pos == IDX_W'(DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = pos + 1'b1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

### hdl/ufq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ufq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/ufq_seq.sv
// Sequencer: ring pointers, entry count and the one-comparator duplicate scan.
`default_nettype none

module ufq_seq
    import ufq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire mode_t                   in_mode,
    input  wire logic [ELEM_FIELD_W-1:0] in_element,
    input  wire logic [ELEMENT_BITS-1:0] rd_data,
    output ram_req_t                     ram_req,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output result_t                      res
);

    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [ELEMENT_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic                    hit_reg, hit_next;
    logic [CNT_W-1:0]        count_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        left_reg <= left_next;
        hit_reg  <= hit_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_mode)
                        MODE_ENQ, MODE_QUERY: state_next = S_SCAN;
                        MODE_DEQ:             state_next = S_DEQ;
                        MODE_CLEAR:           state_next = S_FINISH;
                        default:              state_next = S_FINISH;
                    endcase
                end
            end
            S_SCAN:
            begin
                // Done once every held entry was read and the last read compared.
                if (left_reg == '0 && !cmp_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DEQ:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready  = 1'b1;
            S_FINISH: res_valid = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    // Datapath, memory requests and the result of the finishing cycle.
    always_comb
    begin
        mode_next        = mode_reg;
        key_next         = key_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        left_next        = left_reg;
        cmp_vld_next     = cmp_vld_reg;
        hit_next         = hit_reg;
        count_after      = count_reg;
        ram_req          = '0;
        res.out_element  = '0;
        res.status       = STAT_DONE;
        res.present      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = in_mode;
                    key_next     = ELEMENT_BITS'(in_element);
                    pos_next     = head_reg;
                    left_next    = count_reg;
                    hit_next     = 1'b0;
                    cmp_vld_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // Read one entry per cycle and compare the entry whose read was issued in the previous cycle.
                ram_req.rd_en   = (left_reg != '0);
                ram_req.rd_addr = pos_reg;
                if (left_reg != '0)
                begin
                    pos_next  = ring_next(pos_reg);
                    left_next = left_reg - 1'b1;
                end
                cmp_vld_next = (left_reg != '0);
                if (cmp_vld_reg && rd_data == key_reg)
                begin
                    hit_next = 1'b1;
                end
            end
            S_DEQ:
            begin
                ram_req.rd_en   = (count_reg != '0);
                ram_req.rd_addr = head_reg;
            end
            S_FINISH:
            begin
                unique case (mode_reg)
                    MODE_ENQ:
                    begin
                        res.present = hit_reg;
                        if (hit_reg)
                        begin
                            res.status = STAT_DUP;
                        end
                        else if (count_reg == CNT_W'(DEPTH))
                        begin
                            res.status = STAT_FULL;
                        end
                        else
                        begin
                            count_after     = count_reg + 1'b1;
                            ram_req.wr_en   = res_ready;
                            ram_req.wr_addr = tail_reg;
                            ram_req.wr_data = key_reg;
                            if (res_ready)
                            begin
                                tail_next = ring_next(tail_reg);
                            end
                        end
                    end
                    MODE_DEQ:
                    begin
                        if (count_reg == '0)
                        begin
                            res.status = STAT_EMPTY;
                        end
                        else
                        begin
                            count_after     = count_reg - 1'b1;
                            res.out_element = ELEM_FIELD_W'(rd_data);
                            if (res_ready)
                            begin
                                head_next = ring_next(head_reg);
                            end
                        end
                    end
                    MODE_QUERY:
                    begin
                        res.present = hit_reg;
                    end
                    MODE_CLEAR:
                    begin
                        count_after = '0;
                        if (res_ready)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                    end
                    default:
                    begin
                        count_after = count_reg;
                    end
                endcase
                if (res_ready)
                begin
                    count_next = count_after;
                end
            end
            default:
            begin
                count_after = count_reg;
            end
        endcase

        res.fill_count = FILL_W'(count_after);
    end

endmodule

`default_nettype wire

### hdl/unique_fifo_queue.sv
// Enqueue and query scan every held entry in S_SCAN and then form the result in
// S_FINISH; dequeue reads the head entry in S_DEQ first and clear goes straight to S_FINISH.
// Only one item is handled at a time; s_tready returns high in the cycle after the
// result is registered in the output register.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result;
// the entry RAM is not cleared.
`default_nettype none

module unique_fifo_queue
    import ufq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // element
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // mode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // out_element, fill_count, zero pad
    output logic      [M_TUSER_W-1:0] m_tuser    // status, present
);

    ram_req_t                ram_req;
    logic [ELEMENT_BITS-1:0] rd_data;
    logic                    res_valid;
    logic                    res_ready;
    result_t                 res;
    logic                    m_tvalid_reg, m_tvalid_next;
    result_t                 out_reg;

    ufq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (mode_t'(s_tuser)),
        .in_element (s_tdata[ELEM_FIELD_W-1:0]),
        .rd_data    (rd_data),
        .ram_req    (ram_req),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    ufq_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.fill_count, out_reg.out_element};
    assign m_tuser  = {out_reg.present, out_reg.status};

endmodule

`default_nettype wire

### hdl/ufq_checker.sv
// Port-level checker for the unique FIFO queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module ufq_checker
    import ufq_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    logic [STATUS_W-1:0]     stat;
    logic                    pres;
    logic [FILL_W-1:0]       fill;
    logic [ELEM_FIELD_W-1:0] elem;

    assign stat = m_tuser[STATUS_W-1:0];
    assign pres = m_tuser[STATUS_W];
    assign fill = m_tdata[FILL_LSB +: FILL_W];
    assign elem = m_tdata[ELEM_FIELD_W-1:0];

    // A stalled result beat keeps its contents.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // The block works on one item at a time.
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "input taken again right after a beat")

    // An empty dequeue reports nothing held and no value.
    `ASSERT_IMP(a_empty, clk, rst_n, m_tvalid && stat == STAT_EMPTY,
        fill == '0 && elem == '0 && !pres, "empty result with data or count")

    // A full rejection only happens with the ring full, and a duplicate is always present.
    `ASSERT_IMP(a_full_dup, clk, rst_n, m_tvalid && (stat == STAT_FULL || stat == STAT_DUP),
        (stat == STAT_DUP && pres) || (stat == STAT_FULL && !pres && fill == FILL_W'(DEPTH)),
        "full or duplicate result inconsistent")

endmodule

bind unique_fifo_queue ufq_checker u_ufq_checker (.*);

`default_nettype wire
